### rtl/core/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// types and constants shared by the packet ack tracker modules
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam logic [15:0] INVALID_ACK = 16'hFFFF;
    localparam logic [15:0] HALF_RANGE  = 16'h7FFF;

    typedef enum logic [2:0] {
        ACT_SEND    = 3'd0,
        ACT_NEW     = 3'd1,
        ACT_RESEND  = 3'd2,
        ACT_RECEIVE = 3'd3,
        ACT_QUERY   = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] reliable_id;
        logic [15:0] packet_ack;
        logic [15:0] remote_highest_ack;
        logic [15:0] remote_ack_bits;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] ack_number;
        logic [15:0] header_highest_ack;
        logic [15:0] header_ack_bits;
        logic [15:0] assigned_id;
        logic        granted;
        logic        confirmed;
        logic [15:0] oldest_open_id;
        logic        bundle_full;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_NEXT,
        ST_ADD,
        ST_ACK_SEL,
        ST_ACK_TAG,
        ST_ID_RD,
        ST_ID_CONF,
        ST_ADVANCE,
        ST_OUT
    } t_state;

    // history update for a received ack
    function automatic logic [31:0] hist_update(input logic [15:0] high,
                                                input logic [15:0] bits,
                                                input logic [15:0] ack);
        logic [15:0] ahead;
        logic [15:0] behind;
        logic [15:0] nb;
        logic [15:0] nh;
        begin
            ahead  = ack - high;
            behind = high - ack;
            nb = bits;
            nh = high;
            if (ack != INVALID_ACK) begin
                if (high == INVALID_ACK) begin
                    nh = ack;
                    nb = '0;
                end else if (ahead >= 16'd1 && ahead <= HALF_RANGE) begin
                    nb = (ahead < 16'd16) ? (bits << ahead[3:0]) : 16'd0;
                    if (ahead <= 16'd16) begin
                        nb = nb | (16'd1 << (ahead[4:0] - 5'd1));
                    end
                    nh = ack;
                end else if (behind >= 16'd1 && behind <= 16'd16) begin
                    nb = bits | (16'd1 << (behind[4:0] - 5'd1));
                end
            end
            hist_update = {nh, nb};
        end
    endfunction

endpackage

### rtl/core/packet_ack_reliable_tracker.sv
// ----------------------------------------------------------------------------
// packet_ack_reliable_tracker
// sender side ack bitfield reliability tracker, one small sequencer
// ----------------------------------------------------------------------------
// latency, accepting edge to o_valid: every beat passes dispatch and an output state;
// a query checks the confirm state, a resend or new reliable scans the open bundle
// id by id, and a receive walks the ids of each named bundle and advances the oldest id
// throughput: one beat at a time, the next taken only after the result beat is accepted
// reset: after i_rst_n a clearing pass writes an invalid tag into every slot of the
// tag store before the first beat is taken; config writes are taken always
module packet_ack_reliable_tracker #(
    parameter int BUNDLE_SLOTS   = 64,
    parameter int IDS_PER_BUNDLE = 8,
    parameter int WINDOW         = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pat_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pat_pkg::t_out_beat o_data,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata
);
    import pat_pkg::*;

    localparam int SAW = (BUNDLE_SLOTS > 1) ? $clog2(BUNDLE_SLOTS) : 1;
    localparam int KW  = $clog2(IDS_PER_BUNDLE + 1);
    localparam int IAW = $clog2(BUNDLE_SLOTS * IDS_PER_BUNDLE);
    localparam int WW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WCW = $clog2(WINDOW + 1);

    t_state      r_state, n_state;
    t_in_beat    r_in;
    t_out_beat   r_out, n_out;
    logic        r_ovalid;
    logic [5:0]  r_window;
    logic [15:0] r_next_ack, r_high, r_bits, r_open_ack, r_next_rel, r_oldest;
    logic        r_open;
    logic [WINDOW-1:0] r_cmap;
    logic        r_clearing;
    logic [SAW:0] r_clr;
    logic [4:0]  r_ai, n_ai;
    logic [15:0] r_cur_ack, n_cur_ack;
    logic [15:0] r_id, n_id;
    logic [KW-1:0] r_k, n_k, r_n, n_n;

    // memory ports
    logic            s_we, i_we;
    logic [SAW-1:0]  s_waddr, s_raddr;
    logic [19:0]     s_wdata, s_rdata;
    logic [IAW-1:0]  i_waddr, i_raddr;
    logic [15:0]     i_wdata, i_rdata;

    pat_slot_mem #(.DEPTH(BUNDLE_SLOTS), .AW(SAW)) u_slot (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    pat_id_mem #(.DEPTH(BUNDLE_SLOTS * IDS_PER_BUNDLE), .AW(IAW)) u_ids (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(i_raddr), .o_rdata(i_rdata)
    );

    function automatic logic [SAW-1:0] slot_of(input logic [15:0] a);
        slot_of = SAW'(32'(a) % BUNDLE_SLOTS);
    endfunction
    function automatic logic [IAW-1:0] id_addr(input logic [SAW-1:0] s,
                                               input logic [KW-1:0] k);
        id_addr = IAW'(32'(s) * IDS_PER_BUNDLE + 32'(k));
    endfunction
    function automatic logic [WW-1:0] widx(input logic [15:0] v);
        widx = WW'(32'(v) % WINDOW);
    endfunction

    // shared compare unit: outstanding distance of an id
    logic [15:0] c_outst, c_d, c_behind;
    logic        c_in_win, c_conf;
    logic [15:0] c_tag;
    logic [KW-1:0] c_cnt;
    logic [WCW-1:0] c_w;
    logic [15:0] h_high, h_bits;

    always_comb begin
        c_outst  = r_next_rel - r_oldest;
        c_d      = r_id - r_oldest;
        c_behind = r_oldest - r_id;
        c_in_win = (c_d < c_outst);
        c_conf   = c_in_win ? r_cmap[widx(r_id)]
                            : (c_behind >= 16'd1 && c_behind <= HALF_RANGE);
        c_tag    = s_rdata[19:4];
        c_cnt    = (32'(s_rdata[3:0]) > IDS_PER_BUNDLE) ? KW'(IDS_PER_BUNDLE)
                                                       : KW'(s_rdata[3:0]);
        c_w      = (32'(r_window) > WINDOW) ? WCW'(WINDOW) : WCW'(r_window);
        {h_high, h_bits} = hist_update(r_high, r_bits, r_in.packet_ack);
    end

    assign o_ready = (r_state == ST_IDLE) && !r_clearing && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // next state and datapath strobes
    logic do_send, do_grant, do_conf, do_adv, do_hist, clr_adv;
    always_comb begin
        n_state = r_state;
        n_out = r_out;
        n_ai = r_ai;
        n_cur_ack = r_cur_ack;
        n_id = r_id;
        n_k = r_k;
        n_n = r_n;
        s_we = 1'b0;
        s_waddr = slot_of(r_open_ack);
        s_wdata = '0;
        s_raddr = slot_of(r_open_ack);
        i_we = 1'b0;
        i_waddr = id_addr(slot_of(r_open_ack), r_n);
        i_wdata = r_id;
        i_raddr = id_addr(slot_of(r_open_ack), r_k);
        do_send = 1'b0;
        do_grant = 1'b0;
        do_conf = 1'b0;
        do_adv = 1'b0;
        do_hist = 1'b0;
        clr_adv = 1'b0;
        if (r_clearing) begin
            s_we = 1'b1;
            s_waddr = r_clr[SAW-1:0];
            s_wdata = {INVALID_ACK, 4'd0};
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = ST_DISPATCH;
                    n_out = '0;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_OUT;
                unique case (r_in.action)
                    ACT_SEND: begin
                        do_send = 1'b1;
                        n_out.ack_number = r_next_ack;
                        s_we = 1'b1;
                        s_waddr = slot_of(r_next_ack);
                        s_wdata = {r_next_ack, 4'd0};
                    end
                    ACT_NEW: begin
                        if (32'(c_outst) < 32'(c_w)) begin
                            do_grant = 1'b1;
                            n_out.granted = 1'b1;
                            n_out.assigned_id = r_next_rel;
                            n_id = r_next_rel;
                            n_k = '0;
                            if (r_open) n_state = ST_SCAN_RD;
                            else n_out.bundle_full = 1'b1;
                        end
                    end
                    ACT_RESEND: begin
                        n_id = r_in.reliable_id;
                        n_k = '0;
                        n_state = ST_SCAN_RD;
                    end
                    ACT_RECEIVE: begin
                        do_hist = 1'b1;
                        n_ai = 5'd0;
                        n_state = ST_ACK_SEL;
                    end
                    ACT_QUERY: begin
                        n_id = r_in.reliable_id;
                        n_state = ST_SCAN_NEXT;
                    end
                    default: ;
                endcase
            end
            ST_SCAN_RD: begin
                // read slot count, resend confirm check
                if (r_in.action == ACT_RESEND && c_conf) begin
                    n_out.confirmed = 1'b1;
                    n_state = ST_OUT;
                end else if (r_in.action == ACT_RESEND && !r_open) begin
                    n_out.bundle_full = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                // s_rdata valid: count; i_rdata valid for r_k
                n_n = c_cnt;
                if (r_k >= c_cnt) begin
                    n_state = ST_ADD;
                end else begin
                    n_state = ST_SCAN_NEXT;
                end
            end
            ST_SCAN_NEXT: begin
                if (r_in.action == ACT_QUERY) begin
                    n_out.confirmed = c_conf;
                    n_state = ST_OUT;
                end else if (i_rdata == r_id) begin
                    n_state = ST_OUT;
                end else begin
                    n_k = r_k + KW'(1);
                    i_raddr = id_addr(slot_of(r_open_ack), r_k + KW'(1));
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_ADD: begin
                n_state = ST_OUT;
                if (32'(r_n) >= IDS_PER_BUNDLE) begin
                    n_out.bundle_full = 1'b1;
                end else begin
                    i_we = 1'b1;
                    s_we = 1'b1;
                    s_wdata = {r_open_ack, 4'(r_n + KW'(1))};
                end
            end
            ST_ACK_SEL: begin
                if (r_ai == 5'd17) begin
                    n_state = ST_OUT;
                end else if (r_ai == 5'd0 || r_in.remote_ack_bits[4'(r_ai - 5'd1)]) begin
                    n_cur_ack = r_in.remote_highest_ack - 16'(r_ai);
                    n_state = ST_ACK_TAG;
                end else begin
                    n_ai = r_ai + 5'd1;
                end
                s_raddr = slot_of(n_cur_ack);
            end
            ST_ACK_TAG: begin
                n_k = '0;
                n_n = c_cnt;
                i_raddr = id_addr(slot_of(r_cur_ack), '0);
                if (c_tag != r_cur_ack || c_cnt == '0) begin
                    n_ai = r_ai + 5'd1;
                    n_state = ST_ACK_SEL;
                end else begin
                    n_state = ST_ID_RD;
                end
            end
            ST_ID_RD: begin
                n_id = i_rdata;
                n_state = ST_ID_CONF;
            end
            ST_ID_CONF: begin
                if (c_in_win) do_conf = 1'b1;
                n_state = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                if (r_oldest != r_next_rel && r_cmap[widx(r_oldest)]) begin
                    do_adv = 1'b1;
                end else if (32'(r_k) + 1 < 32'(r_n)) begin
                    n_k = r_k + KW'(1);
                    i_raddr = id_addr(slot_of(r_cur_ack), r_k + KW'(1));
                    n_state = ST_ID_RD;
                end else begin
                    n_ai = r_ai + 5'd1;
                    n_state = ST_ACK_SEL;
                end
            end
            ST_OUT: begin
                n_out.header_highest_ack = r_high;
                n_out.header_ack_bits = r_bits;
                n_out.oldest_open_id = r_oldest;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_ID_RD) i_raddr = id_addr(slot_of(r_cur_ack), r_k);
        clr_adv = r_clearing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_window <= 6'd32;
            r_next_ack <= '0;
            r_high <= INVALID_ACK;
            r_bits <= '0;
            r_open_ack <= '0;
            r_open <= 1'b0;
            r_next_rel <= '0;
            r_oldest <= '0;
            r_cmap <= '0;
            r_clearing <= 1'b1;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_window <= i_cfg_wdata;
            if (clr_adv) begin
                r_clr <= r_clr + (SAW+1)'(1);
                if (32'(r_clr) == BUNDLE_SLOTS - 1) r_clearing <= 1'b0;
            end
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (do_send) begin
                r_next_ack <= (r_next_ack + 16'd1 == INVALID_ACK) ? 16'd0
                                                                 : r_next_ack + 16'd1;
                r_open_ack <= r_next_ack;
                r_open <= 1'b1;
            end
            if (do_grant) begin
                r_cmap[widx(r_next_rel)] <= 1'b0;
                r_next_rel <= r_next_rel + 16'd1;
            end
            if (do_hist) begin
                r_high <= h_high;
                r_bits <= h_bits;
            end
            if (do_conf) r_cmap[widx(r_id)] <= 1'b1;
            if (do_adv) begin
                r_cmap[widx(r_oldest)] <= 1'b0;
                r_oldest <= r_oldest + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && o_ready) r_in <= i_data;
        r_out <= n_out;
        r_ai <= n_ai;
        r_cur_ack <= n_cur_ack;
        r_id <= n_id;
        r_k <= n_k;
        r_n <= n_n;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_no_beat_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_ready) else $error("beat taken during clear");
    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(16'(r_next_rel - r_oldest)) <= WINDOW) else $error("window overrun");
endmodule

### rtl/core/pat_id_mem.sv
// ----------------------------------------------------------------------------
// pat_id_mem
// bundle id store, one write and one registered read port
// ----------------------------------------------------------------------------
module pat_id_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/pat_slot_mem.sv
// ----------------------------------------------------------------------------
// pat_slot_mem
// bundle tag and count store with registered read
// ----------------------------------------------------------------------------
module pat_slot_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [19:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [19:0]   o_rdata
);
    logic [19:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### tb/sv/packet_ack_reliable_tracker_chk.sv
// ----------------------------------------------------------------------------
// packet_ack_reliable_tracker_chk
// watches both channels of the ack tracker, keeps its own copy of the
// tracker state, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module packet_ack_reliable_tracker_chk #(
    parameter int BUNDLE_SLOTS   = 64,
    parameter int IDS_PER_BUNDLE = 8,
    parameter int WINDOW         = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  pat_pkg::t_in_beat  i_data,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  pat_pkg::t_out_beat i_odata,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_beats
);
    timeunit 1ns;
    timeprecision 1ps;
    import pat_pkg::*;

    logic [5:0]  win_reg;
    logic [15:0] m_next_ack, m_high, m_bits, m_open_ack, m_next_rel, m_oldest;
    logic        m_open;
    logic [15:0] m_tag [BUNDLE_SLOTS];
    int          m_cnt [BUNDLE_SLOTS];
    logic [15:0] m_ids [BUNDLE_SLOTS*IDS_PER_BUNDLE];
    logic        m_conf [WINDOW];
    t_out_beat   result_q[$];

    function automatic logic [15:0] outstanding();
        return m_next_rel - m_oldest;
    endfunction

    function automatic logic id_is_confirmed(logic [15:0] id);
        logic [15:0] d, bh;
        d = id - m_oldest;
        bh = m_oldest - id;
        if (d < outstanding()) return m_conf[id % WINDOW];
        return bh >= 1 && bh <= HALF_RANGE;
    endfunction

    task automatic confirm_id(logic [15:0] id);
        logic [15:0] d;
        d = id - m_oldest;
        if (d >= outstanding()) return;
        m_conf[id % WINDOW] = 1'b1;
        while (m_oldest != m_next_rel && m_conf[m_oldest % WINDOW]) begin
            m_conf[m_oldest % WINDOW] = 1'b0;
            m_oldest++;
        end
    endtask

    task automatic confirm_ack(logic [15:0] ack);
        int s, n;
        s = ack % BUNDLE_SLOTS;
        if (m_tag[s] != ack) return;
        n = m_cnt[s] > IDS_PER_BUNDLE ? IDS_PER_BUNDLE : m_cnt[s];
        for (int k = 0; k < n; k++) confirm_id(m_ids[s*IDS_PER_BUNDLE+k]);
    endtask

    function automatic logic bundle_put(logic [15:0] id);
        int s, n;
        if (!m_open) return 1'b1;
        s = m_open_ack % BUNDLE_SLOTS;
        n = m_cnt[s] > IDS_PER_BUNDLE ? IDS_PER_BUNDLE : m_cnt[s];
        for (int k = 0; k < n; k++) if (m_ids[s*IDS_PER_BUNDLE+k] == id) return 1'b0;
        if (n >= IDS_PER_BUNDLE) return 1'b1;
        m_ids[s*IDS_PER_BUNDLE+n] = id;
        m_cnt[s] = n + 1;
        return 1'b0;
    endfunction

    task automatic record_ack(logic [15:0] ack);
        logic [15:0] ahead, bh;
        if (ack == INVALID_ACK) return;
        if (m_high == INVALID_ACK) begin
            m_high = ack;
            m_bits = '0;
            return;
        end
        ahead = ack - m_high;
        bh = m_high - ack;
        if (ahead >= 1 && ahead <= HALF_RANGE) begin
            m_bits = (ahead < 16) ? (m_bits << ahead) : 16'd0;
            if (ahead <= 16) m_bits |= 16'd1 << (ahead - 1);
            m_high = ack;
        end else if (bh >= 1 && bh <= 16) begin
            m_bits |= 16'd1 << (bh - 1);
        end
    endtask

    task automatic predict_tracker(t_in_beat b);
        t_out_beat r;
        logic [15:0] lim;
        r = '0;
        case (b.action)
            ACT_SEND: begin
                r.ack_number = m_next_ack;
                m_next_ack++;
                if (m_next_ack == INVALID_ACK) m_next_ack = '0;
                m_tag[r.ack_number % BUNDLE_SLOTS] = r.ack_number;
                m_cnt[r.ack_number % BUNDLE_SLOTS] = 0;
                m_open_ack = r.ack_number;
                m_open = 1'b1;
            end
            ACT_NEW: begin
                lim = (win_reg > WINDOW) ? 16'(WINDOW) : 16'(win_reg);
                if (outstanding() < lim) begin
                    r.assigned_id = m_next_rel;
                    m_conf[m_next_rel % WINDOW] = 1'b0;
                    m_next_rel++;
                    r.granted = 1'b1;
                    r.bundle_full = bundle_put(r.assigned_id);
                end
            end
            ACT_RESEND: begin
                r.confirmed = id_is_confirmed(b.reliable_id);
                if (!r.confirmed) r.bundle_full = bundle_put(b.reliable_id);
            end
            ACT_RECEIVE: begin
                record_ack(b.packet_ack);
                confirm_ack(b.remote_highest_ack);
                for (int k = 0; k < 16; k++)
                    if (b.remote_ack_bits[k]) confirm_ack(b.remote_highest_ack - 16'(k + 1));
            end
            ACT_QUERY: r.confirmed = id_is_confirmed(b.reliable_id);
            default: ;
        endcase
        r.header_highest_ack = m_high;
        r.header_ack_bits = m_bits;
        r.oldest_open_id = m_oldest;
        result_q = {result_q, r};
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch beat %0d %s: got %h want %h", o_beats, what, got, want);
        o_fail_count++;
    endtask

    t_out_beat w;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg = 6'd32;
            m_next_ack = '0; m_high = INVALID_ACK; m_bits = '0; m_open_ack = '0;
            m_open = 1'b0; m_next_rel = '0; m_oldest = '0;
            for (int k = 0; k < BUNDLE_SLOTS; k++) begin
                m_tag[k] = INVALID_ACK; m_cnt[k] = 0;
            end
            for (int k = 0; k < WINDOW; k++) m_conf[k] = 1'b0;
            result_q.delete();
            o_fail_count = 0;
            o_beats = 0;
        end else begin
            if (i_cfg_we) win_reg = i_cfg_wdata;
            if (i_valid_out && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("unexpected result beat %0d", o_beats);
                    o_fail_count++;
                end else begin
                    w = result_q.pop_front();
                    if (i_odata.ack_number !== w.ack_number)
                        report_mismatch("ack_number", i_odata.ack_number, w.ack_number);
                    if (i_odata.header_highest_ack !== w.header_highest_ack)
                        report_mismatch("header_highest_ack", i_odata.header_highest_ack,
                                        w.header_highest_ack);
                    if (i_odata.header_ack_bits !== w.header_ack_bits)
                        report_mismatch("header_ack_bits", i_odata.header_ack_bits,
                                        w.header_ack_bits);
                    if (i_odata.assigned_id !== w.assigned_id)
                        report_mismatch("assigned_id", i_odata.assigned_id, w.assigned_id);
                    if (i_odata.granted !== w.granted)
                        report_mismatch("granted", 16'(i_odata.granted), 16'(w.granted));
                    if (i_odata.confirmed !== w.confirmed)
                        report_mismatch("confirmed", 16'(i_odata.confirmed), 16'(w.confirmed));
                    if (i_odata.oldest_open_id !== w.oldest_open_id)
                        report_mismatch("oldest_open_id", i_odata.oldest_open_id,
                                        w.oldest_open_id);
                    if (i_odata.bundle_full !== w.bundle_full)
                        report_mismatch("bundle_full", 16'(i_odata.bundle_full),
                                        16'(w.bundle_full));
                end
                o_beats++;
            end
            if (i_valid && i_ready_in) predict_tracker(i_data);
        end
        o_pending = result_q.size();
    end
endmodule

### tb/sv/packet_ack_reliable_tracker_tb.sv
// ----------------------------------------------------------------------------
// packet_ack_reliable_tracker_tb
// drives sends, new and resent reliables, received headers and queries with
// random idling on both channels and several window settings; results are
// checked beat by beat by the checker module
// ----------------------------------------------------------------------------
module packet_ack_reliable_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pat_pkg::*;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, o_ready, o_valid, i_ready = 1'b0, i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;
    t_in_beat i_data = '0;
    t_out_beat o_data;
    int fail_count, pending, beats, cycle_count = 0, sent = 0;
    logic [15:0] recent_ack = '0;
    int stall_left = 0;
    logic rx_armed = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    packet_ack_reliable_tracker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    packet_ack_reliable_tracker_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_data(i_data), .i_valid_out(o_valid), .i_ready(i_ready), .i_odata(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_fail_count(fail_count),
        .o_pending(pending), .o_beats(beats)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 4000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stalls: one fresh wait per result
    always @(negedge i_clk) begin
        if (!i_rst_n || !o_valid) begin
            i_ready <= 1'b0;
            rx_armed = 1'b0;
        end else if (!rx_armed) begin
            rx_armed = 1'b1;
            stall_left = $urandom_range(3) == 0 ? 0 : $urandom_range(15);
            i_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= (stall_left == 0);
        end
    end

    task automatic send_beat(t_in_beat b, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data <= b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_window(logic [5:0] v);
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_beat make_beat(logic [2:0] act, logic [15:0] rid,
                                           logic [15:0] pa, logic [15:0] rh,
                                           logic [15:0] rb);
        t_in_beat b;
        b.action = act; b.reliable_id = rid; b.packet_ack = pa;
        b.remote_highest_ack = rh; b.remote_ack_bits = rb;
        return b;
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        int r;
        b = {$urandom, $urandom, 3'($urandom)};
        r = $urandom_range(99);
        if (r < 20) b.action = ACT_SEND;
        else if (r < 45) b.action = ACT_NEW;
        else if (r < 60) begin
            b.action = ACT_RESEND;
            if ($urandom_range(3) != 0)
                b.reliable_id = u_chk.m_next_rel - 16'($urandom_range(40));
        end else if (r < 85) begin
            b.action = ACT_RECEIVE;
            if ($urandom_range(3) != 0) begin
                b.remote_highest_ack = recent_ack - 16'($urandom_range(4));
                b.packet_ack = 16'(recent_ack + $urandom_range(20) - 10);
            end
        end else if (r < 95) begin
            b.action = ACT_QUERY;
            if ($urandom_range(1))
                b.reliable_id = u_chk.m_next_rel - 16'($urandom_range(40));
        end else begin
            b.action = 3'(5 + $urandom_range(2));
        end
        return b;
    endfunction

    initial begin
        t_in_beat b;
        int gap;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed part: no packet yet, first ack, invalid ack, full bundle
        send_beat(make_beat(ACT_NEW, 16'd0, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RESEND, 16'd0, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_QUERY, 16'hFFFF, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'd5, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'd5, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'd3, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'd25, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'h9000, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_SEND, 16'd0, 16'd0, 16'd0, 16'd0), 0);
        for (int k = 0; k < 9; k++)
            send_beat(make_beat(ACT_NEW, 16'd0, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RESEND, 16'd1, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_RECEIVE, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF), 0);
        send_beat(make_beat(ACT_RESEND, 16'd1, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(ACT_QUERY, 16'd8, 16'd0, 16'd0, 16'd0), 0);
        send_beat(make_beat(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_window(6'd1);
                1: write_window(6'd63);
                2: write_window(6'd0);
                3: write_window(6'($urandom_range(2, 31)));
                default: write_window(6'd32);
            endcase
            for (int n = 0; n < 250; n++) begin
                b = random_beat();
                if (b.action == ACT_SEND) recent_ack = u_chk.m_next_ack;
                gap = $urandom_range(2) == 0 ? 0 : $urandom_range(15);
                send_beat(b, gap);
            end
        end
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        $display("%0d beats sent, %0d results checked over five window settings", sent, beats);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
